// ===== design/edd_pkg.sv =====
// Shared definitions for the error diffusion dither block.
// Holds default sizes, register widths, reset values and indexes, and the per-pixel flag struct.
// No dependencies.
package edd_pkg;

	// default sizes for the top level parameters
	localparam int unsigned EDD_MAX_WIDTH  = 2048;
	localparam int unsigned EDD_ERROR_BITS = 10;

	// configuration register widths and reset values
	localparam int unsigned CFG_DATA_W        = 16;
	localparam int unsigned IMAGE_WIDTH_BITS  = 12;
	localparam int unsigned IMAGE_HEIGHT_BITS = 16;
	localparam logic [IMAGE_WIDTH_BITS-1:0]  IMAGE_WIDTH_RESET  = 12'd640;
	localparam logic [IMAGE_HEIGHT_BITS-1:0] IMAGE_HEIGHT_RESET = 16'd480;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// position flags that travel with a pixel down the pipeline
	typedef struct packed {
		logic has_up;
		logic has_left;
		logic row_end;
		logic frame_end;
	} pix_flags_t;

endpackage

// ===== design/edd_row_ram.sv =====
// Simple dual-port row buffer for the error diffusion dither block.
// One write port, one read port with registered read data; no dependencies.
module edd_row_ram #(
	parameter int unsigned DEPTH  = 2048,
	parameter int unsigned DATA_W = 10
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [$clog2(DEPTH)-1:0]        waddr,
	input  logic [DATA_W-1:0]               wdata,
	input  logic                            re,
	input  logic [$clog2(DEPTH)-1:0]        raddr,
	output logic [DATA_W-1:0]               rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/error_diffusion_dither_top.sv =====
// Two-level error diffusion dither, top level.
// Uses edd_pkg and edd_row_ram (the previous row's error buffer).
//
// Usage:
//   Gray pixels enter in raster order on pixel_valid / pixel_stall with
//   pixel_in; one request per pixel. Each pixel gives one result request on
//   dither_valid / dither_stall: pixel_out (0 or 255), row_end, frame_end.
//   image_width and image_height are written through cfg_we / cfg_index /
//   cfg_data while the block is idle.
//   A pixel is taken into the stage 1 registers together with its row
//   buffer read; stage 1 adds the upper error shares, stage 2 adds the
//   left error share and decides, and the result register holds the result.
//   Throughput: one pixel per clock for widths of three and more while the
//   receiver does not stall. The row buffer read of a pixel waits until the
//   pixel of the same column in the row above has written back its error,
//   so at widths 1 and 2 a new pixel cannot be taken on every clock.
//   Reset sets 640 x 480, returns the raster position to the top-left
//   corner and empties the pipeline; the row buffer is not cleared since
//   the first row does not use what it reads.
//   When the receiver stalls, the result holds, the stages behind it fill
//   up and pixel_stall rises once no stage can move.
module error_diffusion_dither_top #(
	parameter int unsigned MAX_WIDTH  = edd_pkg::EDD_MAX_WIDTH,
	parameter int unsigned ERROR_BITS = edd_pkg::EDD_ERROR_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  edd_pkg::cfg_reg_t               cfg_index,
	input  logic [edd_pkg::CFG_DATA_W-1:0]  cfg_data,
	// gray pixels
	input  logic                            pixel_valid,
	output logic                            pixel_stall,
	input  logic [7:0]                      pixel_in,
	// dithered pixels
	output logic                            dither_valid,
	input  logic                            dither_stall,
	output logic [7:0]                      pixel_out,
	output logic                            row_end,
	output logic                            frame_end
);

	import edd_pkg::*;

	localparam int unsigned CW    = $clog2(MAX_WIDTH);
	localparam int unsigned WB    = $clog2(MAX_WIDTH + 1);
	localparam int unsigned CMP_W = (WB > IMAGE_WIDTH_BITS) ? WB : IMAGE_WIDTH_BITS;
	localparam int unsigned EB    = ERROR_BITS;
	localparam int unsigned AW    = ERROR_BITS + 2;
	localparam int unsigned SW    = ERROR_BITS + 5;

	localparam logic signed [AW-1:0] SAT_HI = AW'((1 << (ERROR_BITS - 1)) - 1);
	localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);
	localparam logic signed [AW-1:0] THRESH = AW'(128);
	localparam logic signed [AW-1:0] WHITE  = AW'(255);

	// sign-extend an error to the sum width
	function automatic logic signed [SW-1:0] ext_err(input logic signed [EB-1:0] e);
		return {{(SW-EB){e[EB-1]}}, e};
	endfunction

	// sign-extend a value to the sum width
	function automatic logic signed [SW-1:0] ext_val(input logic signed [AW-1:0] v);
		return {{(SW-AW){v[AW-1]}}, v};
	endfunction

	// divide by four, truncating toward zero
	function automatic logic signed [AW-1:0] quarter(input logic signed [SW-1:0] s);
		logic signed [SW-1:0] adj;
		adj = s[SW-1] ? s + SW'(3) : s;
		adj = adj >>> 2;
		return adj[AW-1:0];
	endfunction

	// divide by eight, truncating toward zero
	function automatic logic signed [AW-1:0] eighth(input logic signed [SW-1:0] s);
		logic signed [SW-1:0] adj;
		adj = s[SW-1] ? s + SW'(7) : s;
		adj = adj >>> 3;
		return adj[AW-1:0];
	endfunction

	// configuration registers
	logic [IMAGE_WIDTH_BITS-1:0]  image_width_q;
	logic [IMAGE_HEIGHT_BITS-1:0] image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RESET;
			image_height_q <= IMAGE_HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[IMAGE_WIDTH_BITS-1:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[IMAGE_HEIGHT_BITS-1:0];
			endcase
		end
	end

	// pipeline control
	logic                     v_s1, v_s2, out_v_q;
	logic                     accept, s1_go, s2_go, s1_free, s2_free, out_free;
	logic                     hazard;
	logic [CW-1:0]            col_q, x_s1, x_s2;
	logic [IMAGE_HEIGHT_BITS-1:0] row_q;

	assign out_free = !out_v_q || !dither_stall;
	assign s2_go    = v_s2 && out_free;
	assign s2_free  = !v_s2 || out_free;
	assign s1_go    = v_s1 && s2_free;
	assign s1_free  = !v_s1 || s2_free;

	// hold the pixel while the error of its column is still in flight
	assign hazard      = (v_s1 && (x_s1 == col_q)) || (v_s2 && (x_s2 == col_q));
	assign pixel_stall = !s1_free || hazard;
	assign accept      = pixel_valid && !pixel_stall;

	// raster position and row / image end
	logic [CMP_W-1:0]             eff_width, col_p1;
	logic [IMAGE_HEIGHT_BITS-1:0] eff_height;
	logic [IMAGE_HEIGHT_BITS:0]   row_p1;
	pix_flags_t                   flags_in;

	always_comb begin
		eff_width = CMP_W'(image_width_q);
		if (image_width_q == '0) begin
			eff_width = CMP_W'(1);
		end else if (CMP_W'(image_width_q) > CMP_W'(MAX_WIDTH)) begin
			eff_width = CMP_W'(MAX_WIDTH);
		end
		eff_height = (image_height_q == '0) ? IMAGE_HEIGHT_BITS'(1) : image_height_q;
		col_p1     = CMP_W'(col_q) + CMP_W'(1);
		row_p1     = {1'b0, row_q} + (IMAGE_HEIGHT_BITS+1)'(1);
		flags_in.has_up    = row_q != '0;
		flags_in.has_left  = col_q != '0;
		flags_in.row_end   = col_p1 >= eff_width;
		flags_in.frame_end = flags_in.row_end && (row_p1 >= {1'b0, eff_height});
	end

	// advance the raster position on each request taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (flags_in.row_end) begin
				col_q <= '0;
				row_q <= flags_in.frame_end ? '0 : row_p1[IMAGE_HEIGHT_BITS-1:0];
			end else begin
				col_q <= col_p1[CW-1:0];
			end
		end
	end

	// previous row's errors
	logic                 wr_en;
	logic signed [EB-1:0] err;
	logic        [EB-1:0] up_rd;

	assign wr_en = s2_go;

	edd_row_ram #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (ERROR_BITS)
	) u_row_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (x_s2),
		.wdata (err),
		.re    (accept),
		.raddr (col_q),
		.rdata (up_rd)
	);

	// stage 1 registers
	logic [7:0]  pix_s1;
	pix_flags_t  flags_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1   <= pixel_in;
			flags_s1 <= flags_in;
			x_s1     <= col_q;
		end
	end

	// stage 1: add the upper-left and upper shares
	logic signed [EB-1:0] upleft_q;
	logic signed [EB-1:0] old_up;
	logic signed [AW-1:0] pix_v, v1, v2;
	logic signed [SW-1:0] sum_a, sum_b;

	always_comb begin
		old_up = flags_s1.has_up ? $signed(up_rd) : '0;
		pix_v  = $signed({{(AW-8){1'b0}}, pix_s1});
		sum_a  = (ext_val(pix_v) <<< 2) + ext_err(upleft_q);
		v1     = (flags_s1.has_up && flags_s1.has_left) ? quarter(sum_a) : pix_v;
		sum_b  = (ext_val(v1) <<< 3) + (ext_err(old_up) <<< 1) + ext_err(old_up);
		v2     = flags_s1.has_up ? eighth(sum_b) : v1;
	end

	// keep the upper error of the pixel just passed; clear at a row end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upleft_q <= '0;
		end else if (s1_go) begin
			upleft_q <= flags_s1.row_end ? '0 : old_up;
		end
	end

	// stage 2 registers
	logic signed [AW-1:0] part_s2;
	pix_flags_t           flags_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= s1_go;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			part_s2  <= v2;
			flags_s2 <= flags_s1;
			x_s2     <= x_s1;
		end
	end

	// stage 2: add the left share, saturate, decide, form the error
	logic signed [EB-1:0] left_q;
	logic signed [SW-1:0] sum_c;
	logic signed [AW-1:0] v3, v_sat, err_wide;
	logic                 white;

	always_comb begin
		sum_c = (ext_val(part_s2) <<< 3) + (ext_err(left_q) <<< 1) + ext_err(left_q);
		v3    = flags_s2.has_left ? eighth(sum_c) : part_s2;
		priority if (v3 > SAT_HI) begin
			v_sat = SAT_HI;
		end else if (v3 < SAT_LO) begin
			v_sat = SAT_LO;
		end else begin
			v_sat = v3;
		end
		white    = v_sat > THRESH;
		err_wide = white ? v_sat - WHITE : v_sat;
		err      = err_wide[EB-1:0];
	end

	// carry the error to the right neighbor; drop it at a row end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (s2_go) begin
			left_q <= flags_s2.row_end ? '0 : err;
		end
	end

	// result register
	logic [7:0] pixel_out_q;
	logic       row_end_q, frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= s2_go;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			pixel_out_q <= {8{white}};
			row_end_q   <= flags_s2.row_end;
			frame_end_q <= flags_s2.frame_end;
		end
	end

	assign dither_valid = out_v_q;
	assign pixel_out    = pixel_out_q;
	assign row_end      = row_end_q;
	assign frame_end    = frame_end_q;

	// checks
	a_binary_out: assert property (@(posedge clk) disable iff (!arst_n)
		dither_valid |-> (pixel_out == 8'd0 || pixel_out == 8'hFF))
		else $error("dithered pixel is neither black nor white");

	a_frame_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		dither_valid && frame_end |-> row_end)
		else $error("image end without row end");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && s2_go && (x_s2 == col_q)))
		else $error("row buffer read and write of one column at the same edge");

	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && flags_in.row_end |=> (col_q == '0))
		else $error("column did not return to zero after a row end");

	a_left_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		s2_go && flags_s2.row_end |=> (left_q == '0))
		else $error("left error carried across a row end");

endmodule

// ===== dv/error_diffusion_dither_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for error_diffusion_dither_top: a directed step table, then random
// frames, each dithered pixel checked against a behavioral dither model or a typed table result.
// Depends on edd_pkg and the design under dv's sibling design folder.
module error_diffusion_dither_top_test;
	import edd_pkg::*;

	localparam int ROW_SLOTS      = EDD_MAX_WIDTH;
	localparam int ERR_MAX        = (1 << (EDD_ERROR_BITS - 1)) - 1;
	localparam int ERR_MIN        = -ERR_MAX - 1;
	localparam int THRESHOLD      = 128;
	localparam int WHITE          = 255;
	localparam int RANDOM_PIXELS  = 1600;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int FRAME_CAP      = 300;
	localparam int STEP_COUNT     = 26;

	typedef struct packed {
		logic [7:0] level;
		logic       row_end;
		logic       frame_end;
	} dither_result_t;

	typedef enum logic [0:0] {
		STEP_PIXEL  = 1'b0,
		STEP_CONFIG = 1'b1
	} step_kind_t;

	typedef struct packed {
		step_kind_t              kind;
		cfg_reg_t                reg_index;
		logic [CFG_DATA_W-1:0]   value;
		logic                    typed;
		dither_result_t          result;
	} stim_step_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	cfg_reg_t              cfg_index    = CFG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  pixel_valid  = 1'b0;
	logic                  pixel_stall;
	logic [7:0]            pixel_in     = '0;
	logic                  dither_valid;
	logic                  dither_stall = 1'b0;
	logic [7:0]            pixel_out;
	logic                  row_end;
	logic                  frame_end;

	// dither model state
	int                           row_err_mem [ROW_SLOTS];
	bit                           row_err_written [ROW_SLOTS];
	int                           left_err;
	int                           upleft_err;
	logic [10:0]                  col_pos;
	logic [15:0]                  row_pos;
	logic [IMAGE_WIDTH_BITS-1:0]  width_reg;
	logic [IMAGE_HEIGHT_BITS-1:0] height_reg;

	dither_result_t results_due [$];
	int             fail_count  = 0;
	int             checked     = 0;
	int             idle_cycles = 0;
	int             stall_left  = 0;
	bit             quiet_phase = 1'b0;

	// directed steps: reset size, clamps of zero, mid-image writes, extremes, diffusion
	stim_step_t directed_steps [STEP_COUNT] = '{
		'{STEP_PIXEL,  CFG_IMAGE_WIDTH,  16'd255,    1'b1, '{8'd255, 1'b0, 1'b0}},
		'{STEP_PIXEL,  CFG_IMAGE_WIDTH,  16'd0,      1'b0, '{8'd0,   1'b0, 1'b0}},
		'{STEP_CONFIG, CFG_IMAGE_WIDTH,  16'd0,      1'b0, '{8'd0,   1'b0, 1'b0}},
		'{STEP_CONFIG, CFG_IMAGE_HEIGHT, 16'd0,      1'b0, '{8'd0,   1'b0, 1'b0}},
		'{STEP_PIXEL,  CFG_IMAGE_WIDTH,  16'd128,    1'b1, '{8'd0,   1'b1, 1'b1}},
		'{STEP_PIXEL,  CFG_IMAGE_WIDTH,  16'd0,      1'b1, '{8'd0,   1'b1, 1'b1}},
		'{STEP_PIXEL,  CFG_IMAGE_WIDTH,  16'd255,    1'b1, '{8'd255, 1'b1, 1'b1}},
		'{STEP_PIXEL,  CFG_IMAGE_WIDTH,  16'd129,    1'b1, '{8'd255, 1'b1, 1'b1}},
		'{STEP_PIXEL,  CFG_IMAGE_WIDTH,  16'd128,    1'b1, '{8'd0,   1'b1, 1'b1}},
		'{STEP_CONFIG, CFG_IMAGE_WIDTH,  16'hF003,   1'b0, '{8'd0,   1'b0, 1'b0}},
		'{STEP_CONFIG, CFG_IMAGE_HEIGHT, 16'd2,      1'b0, '{8'd0,   1'b0, 1'b0}},
		'{STEP_PIXEL,  CFG_IMAGE_WIDTH,  16'd200,    1'b0, '{8'd0,   1'b0, 1'b0}},
		'{STEP_PIXEL,  CFG_IMAGE_WIDTH,  16'd100,    1'b0, '{8'd0,   1'b0, 1'b0}},
		'{STEP_PIXEL,  CFG_IMAGE_WIDTH,  16'd255,    1'b0, '{8'd0,   1'b0, 1'b0}},
		'{STEP_PIXEL,  CFG_IMAGE_WIDTH,  16'd0,      1'b0, '{8'd0,   1'b0, 1'b0}},
		'{STEP_PIXEL,  CFG_IMAGE_WIDTH,  16'd77,     1'b0, '{8'd0,   1'b0, 1'b0}},
		'{STEP_PIXEL,  CFG_IMAGE_WIDTH,  16'd129,    1'b0, '{8'd0,   1'b0, 1'b0}},
		'{STEP_CONFIG, CFG_IMAGE_WIDTH,  16'd2,      1'b0, '{8'd0,   1'b0, 1'b0}},
		'{STEP_CONFIG, CFG_IMAGE_HEIGHT, 16'hFFFF,   1'b0, '{8'd0,   1'b0, 1'b0}},
		'{STEP_PIXEL,  CFG_IMAGE_WIDTH,  16'd255,    1'b0, '{8'd0,   1'b0, 1'b0}},
		'{STEP_PIXEL,  CFG_IMAGE_WIDTH,  16'd255,    1'b0, '{8'd0,   1'b0, 1'b0}},
		'{STEP_PIXEL,  CFG_IMAGE_WIDTH,  16'd0,      1'b0, '{8'd0,   1'b0, 1'b0}},
		'{STEP_PIXEL,  CFG_IMAGE_WIDTH,  16'd0,      1'b0, '{8'd0,   1'b0, 1'b0}},
		'{STEP_CONFIG, CFG_IMAGE_HEIGHT, 16'd1,      1'b0, '{8'd0,   1'b0, 1'b0}},
		'{STEP_PIXEL,  CFG_IMAGE_WIDTH,  16'd60,     1'b0, '{8'd0,   1'b0, 1'b0}},
		'{STEP_PIXEL,  CFG_IMAGE_WIDTH,  16'd61,     1'b0, '{8'd0,   1'b0, 1'b0}}
	};

	error_diffusion_dither_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_in     (pixel_in),
		.dither_valid (dither_valid),
		.dither_stall (dither_stall),
		.pixel_out    (pixel_out),
		.row_end      (row_end),
		.frame_end    (frame_end)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int eff_width(logic [IMAGE_WIDTH_BITS-1:0] value);
		if (value == 0) return 1;
		if (int'(value) > ROW_SLOTS) return ROW_SLOTS;
		return int'(value);
	endfunction

	function automatic int eff_height(logic [IMAGE_HEIGHT_BITS-1:0] value);
		return (value == 0) ? 1 : int'(value);
	endfunction

	// exact acc + num * err / den, truncated toward zero
	function automatic int spread_err(int acc, int err, int num, int den);
		return (acc * den + num * err) / den;
	endfunction

	// mostly no gap, some short, a few long; none in quiet phases
	function automatic int pick_gap();
		int r;
		if (quiet_phase) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 120);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_width();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return '0;
		if (r <= 2) return CFG_DATA_W'(r);
		if (r < 15) return CFG_DATA_W'($urandom_range(3, 12));
		if (r < 19) return CFG_DATA_W'($urandom_range(13, 64));
		// junk above the register width must be ignored
		return {4'($urandom_range(1, 15)), 12'($urandom_range(1, 12))};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_height();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return CFG_DATA_W'($urandom_range(1, 4));
	endfunction

	// a new width is safe when no row entry is read before it is written
	function automatic bit width_safe(logic [CFG_DATA_W-1:0] value);
		int w;
		int last;
		bit ok;
		w = eff_width(value[IMAGE_WIDTH_BITS-1:0]);
		ok = 1'b1;
		if (row_pos != 0) begin
			last = (w - 1 > int'(col_pos)) ? w - 1 : int'(col_pos);
			for (int i = int'(col_pos); i <= last; i++) begin
				if (!row_err_written[i]) ok = 1'b0;
			end
		end
		return ok;
	endfunction

	// advance the dither model by one gray pixel
	task automatic dither_pixel(input logic [7:0] gray, output dither_result_t res);
		int w;
		int h;
		int x;
		int v;
		int up;
		int err;
		bit has_up;
		bit has_left;
		w = eff_width(width_reg);
		h = eff_height(height_reg);
		x = int'(col_pos);
		has_up = row_pos != 0;
		has_left = x != 0;
		up = has_up ? row_err_mem[x] : 0;
		v = int'(gray);
		if (has_up && has_left) v = spread_err(v, upleft_err, 1, 4);
		if (has_up) v = spread_err(v, up, 3, 8);
		if (has_left) v = spread_err(v, left_err, 3, 8);
		if (v > ERR_MAX) v = ERR_MAX;
		else if (v < ERR_MIN) v = ERR_MIN;

		// two-level decision
		if (v > THRESHOLD) begin
			res.level = 8'(WHITE);
			err = v - WHITE;
		end else begin
			res.level = 8'd0;
			err = v;
		end
		upleft_err = up;
		row_err_mem[x] = err;
		row_err_written[x] = 1'b1;
		left_err = err;

		// advance the raster position
		res.row_end = (x + 1 >= w);
		res.frame_end = 1'b0;
		if (res.row_end) begin
			col_pos = '0;
			left_err = 0;
			upleft_err = 0;
			if (int'(row_pos) + 1 >= h) begin
				res.frame_end = 1'b1;
				row_pos = '0;
			end else begin
				row_pos = row_pos + 1'b1;
			end
		end else begin
			col_pos = col_pos + 1'b1;
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// issue one pixel request, hold it until taken, then queue its result
	task automatic send_pixel(input logic [7:0] level, input bit typed,
			input dither_result_t typed_result);
		int gap;
		dither_result_t due;
		gap = pick_gap();
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_in <= level;
		do @(posedge clk); while (pixel_stall);
		dither_pixel(level, due);
		results_due.push_back(typed ? typed_result : due);
		@(negedge clk);
	endtask

	// drop the request and let every queued result come out
	task automatic wait_idle();
		pixel_valid <= 1'b0;
		while (results_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// caller lowers cfg_we after the last write of a group
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == CFG_IMAGE_WIDTH) width_reg = value[IMAGE_WIDTH_BITS-1:0];
		else height_reg = value;
		@(negedge clk);
	endtask

	// random stall on the result side
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else if (dither_stall) begin
			dither_stall <= 1'b0;
		end else begin
			stall_left = pick_gap();
			if (stall_left > 0) begin
				dither_stall <= 1'b1;
				stall_left--;
			end
		end
	end

	// compare each taken result with the oldest queued one
	always @(posedge clk) begin
		dither_result_t want;
		if (arst_n && dither_valid && !dither_stall) begin
			if (results_due.size() == 0) begin
				report_mismatch($sformatf("result %0d with nothing queued", checked));
			end else begin
				want = results_due.pop_front();
				if (pixel_out !== want.level)
					report_mismatch($sformatf("result %0d pixel_out %0d, want %0d",
						checked, pixel_out, want.level));
				if (row_end !== want.row_end)
					report_mismatch($sformatf("result %0d row_end %b, want %b",
						checked, row_end, want.row_end));
				if (frame_end !== want.frame_end)
					report_mismatch($sformatf("result %0d frame_end %b, want %b",
						checked, frame_end, want.frame_end));
			end
			checked++;
		end
	end

	// end the run when no request moves for too long
	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (dither_valid && !dither_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int idx;
		int n;
		int pattern;
		int base;
		int level;
		int sent;
		int to_end;
		int w;
		int h;
		bit wide_done;
		bit wide_phase;
		bit boundary;
		bit well_formed;
		logic [CFG_DATA_W-1:0] val;

		// model reset state
		width_reg = IMAGE_WIDTH_RESET;
		height_reg = IMAGE_HEIGHT_RESET;
		col_pos = '0;
		row_pos = '0;
		left_err = 0;
		upleft_err = 0;

		// hold reset, then release it
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// walk the directed table
		for (idx = 0; idx < STEP_COUNT; idx++) begin
			if (directed_steps[idx].kind == STEP_CONFIG) begin
				if (idx == 0 || directed_steps[idx - 1].kind != STEP_CONFIG) wait_idle();
				write_reg(directed_steps[idx].reg_index, directed_steps[idx].value);
			end else begin
				cfg_we <= 1'b0;
				send_pixel(directed_steps[idx].value[7:0], directed_steps[idx].typed,
					directed_steps[idx].result);
			end
		end

		// random phases, one full-width frame among them
		sent = 0;
		wide_done = 1'b0;
		while (sent < RANDOM_PIXELS || !wide_done) begin
			wait_idle();
			quiet_phase = ($urandom_range(0, 4) == 0);
			boundary = (col_pos == 0) && (row_pos == 0);
			well_formed = ($urandom_range(0, 9) < 7);
			wide_phase = 1'b0;
			if (boundary && !wide_done && ($urandom_range(0, 15) == 0 || sent >= RANDOM_PIXELS)) begin
				write_reg(CFG_IMAGE_WIDTH, $urandom_range(0, 1) ? CFG_DATA_W'(ROW_SLOTS) : '1);
				write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(1));
				wide_done = 1'b1;
				wide_phase = 1'b1;
				well_formed = 1'b1;
			end else if (boundary) begin
				if ($urandom_range(0, 4) != 0) write_reg(CFG_IMAGE_WIDTH, pick_width());
				if ($urandom_range(0, 4) != 0) write_reg(CFG_IMAGE_HEIGHT, pick_height());
			end else begin
				// mid-image: maybe write a small height, maybe a new width where no stale read follows
				if (sent >= RANDOM_PIXELS) begin
					write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(1));
					well_formed = 1'b1;
				end else if ($urandom_range(0, 2) == 0) begin
					write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(1, 4)));
				end
				val = pick_width();
				if ($urandom_range(0, 2) == 0 && width_safe(val)) write_reg(CFG_IMAGE_WIDTH, val);
			end
			cfg_we <= 1'b0;

			// pixels left in the current frame
			w = eff_width(width_reg);
			h = eff_height(height_reg);
			to_end = (int'(col_pos) >= w) ? 1 : w - int'(col_pos);
			if (int'(row_pos) + 1 < h) to_end += (h - int'(row_pos) - 1) * w;
			n = well_formed ? to_end : $urandom_range(1, 40);
			if (!wide_phase && n > FRAME_CAP) n = FRAME_CAP;

			pattern = $urandom_range(0, 9);
			base = $urandom_range(0, 255);
			for (int i = 0; i < n; i++) begin
				case (pattern)
					6: begin
						level = $urandom_range(0, 1) ? WHITE : 0;
					end
					7: begin
						level = $urandom_range(THRESHOLD - 8, THRESHOLD + 8);
					end
					8: begin
						level = base;
					end
					default: begin
						level = $urandom_range(0, 255);
					end
				endcase
				send_pixel(8'(level), 1'b0, '0);
				sent++;
			end
		end

		// drain and report
		quiet_phase = 1'b0;
		wait_idle();
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
